// ----- sv/apg_pkg.sv -----
// apg_pkg: shared types, constants and the arctangent table of the arc point generator
// no dependencies; used by every apg_* module and by arc_point_generator
package apg_pkg;

  localparam int MAX_POINTS_DEF   = 64;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int FRAC_BITS        = 16;
  localparam int ANG_FRAC         = FRAC_BITS + 16;
  localparam int ATAN_N           = 32;
  localparam int QUEUE_DEPTH      = 4;
  localparam int DIV_W            = 49;
  localparam int RED_STEPS        = 16;
  localparam int MUL_DIGITS       = 5;
  localparam int D2R_W            = 55;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [D2R_W-1:0] DEG2RAD_Q60 = D2R_W'(PI_Q60 / 64'd180);
  localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

  localparam logic [DIV_W-1:0] FULL_DEG = DIV_W'(360) << FRAC_BITS;
  localparam logic [40:0] FULL_ANG    = 41'd360 << ANG_FRAC;
  localparam logic [40:0] QUARTER_ANG = 41'd90 << ANG_FRAC;
  localparam logic [40:0] HALF_Q_ANG  = 41'd45 << ANG_FRAC;

  typedef enum logic [2:0] {
    REG_BAR_COUNT   = 3'd0,
    REG_FULL_CIRCLE = 3'd1,
    REG_START_ANGLE = 3'd2,
    REG_END_ANGLE   = 3'd3,
    REG_CENTER_X    = 3'd4,
    REG_CENTER_Y    = 3'd5,
    REG_ARC_RADIUS  = 3'd6,
    REG_BAR_AREA    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [6:0]         bar_count;
    logic               full_circle;
    logic signed [31:0] start_angle;
    logic signed [31:0] end_angle;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        arc_radius;
    logic [30:0]        bar_area;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         tag;
    logic [5:0]         idx;
    logic [1:0]         quad;
    logic signed [63:0] z;
    logic               empty;
    logic               last;
  } item_t;

  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] dividend;
    logic [6:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    F_IDLE, F_EMPTY, F_DIV_FC, F_PREP, F_DIV_STEP, F_ANG, F_RED_INIT, F_RED,
    F_RFIX, F_QSEL, F_QADJ, F_MUL, F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {B_IDLE, B_ITER, B_ROT, B_OUT} back_state_t;

  // arctangent table, 60 fraction bits, built at elaboration
  function automatic logic [ATAN_N*64-1:0] atan_table();
    logic [ATAN_N*64-1:0] t;
    logic signed [63:0]   acc;
    logic [63:0]          term;
    int                   e;
    int                   d;
    t = '0;
    for (int i = 0; i < ATAN_N; i++) begin
      if (i == 0) begin
        acc = $signed(PI_Q60 >> 2);
      end else begin
        acc = '0;
        for (int k = 0; k < 31; k++) begin
          e = i * (2 * k + 1);
          if (e <= 60) begin
            d = 2 * k + 1;
            term = (64'd1 << (60 - e)) / 64'(d);
            if (k % 2 == 1) acc = acc - $signed(term);
            else acc = acc + $signed(term);
          end
        end
      end
      t[i*64 +: 64] = acc;
    end
    return t;
  endfunction

endpackage

// ----- sv/apg_div.sv -----
// apg_div: restoring divider, one quotient bit per cycle
// depends on apg_pkg (div_req_t, div_rsp_t, DIV_W)
module apg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  apg_pkg::div_req_t req_i,
  output apg_pkg::div_rsp_t rsp_o
);

  localparam int W = apg_pkg::DIV_W;
  localparam int CW = $clog2(W + 1);

  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  sh_r, sh_nxt;
  logic [6:0]    rem_r, rem_nxt;
  logic [6:0]    dvs_r, dvs_nxt;
  logic [7:0]    trial;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, sh_r[W-1]};
    if (req_i.go) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(W);
      sh_nxt  = req_i.dividend;
      rem_nxt = '0;
      dvs_nxt = req_i.divisor;
    end else if (run_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 7'(trial - {1'b0, dvs_r});
        sh_nxt  = {sh_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[6:0];
        sh_nxt  = {sh_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp_o.done = done_r;
  assign rsp_o.quot = sh_r;

endmodule

// ----- sv/apg_fifo.sv -----
// apg_fifo: short queue of point jobs between front and back end
// depends on apg_pkg (item_t, QUEUE_DEPTH)
module apg_fifo #(
  parameter int DEPTH = apg_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  apg_pkg::item_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output apg_pkg::item_t pop_data_o,
  output logic           not_empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  apg_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [NW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push_i) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_r + 1'b1);
    if (pop_i) rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_r + 1'b1);
    if (push_i && !pop_i) cnt_nxt = cnt_r + 1'b1;
    else if (!push_i && pop_i) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push_i) mem_r[wr_r] <= push_data_i;
  end

  assign full_o      = (cnt_r == NW'(DEPTH));
  assign not_empty_o = (cnt_r != '0);
  assign pop_data_o  = mem_r[rd_r];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push_i && full_o))
    else $error("point queue written while full");
`endif

endmodule

// ----- sv/apg_front.sv -----
// apg_front: takes a request, works out the angle step, reduces each angle
// to a quadrant and a radian residue and queues one job per point; uses apg_pkg
module apg_front #(
  parameter int MAX_POINTS = apg_pkg::MAX_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go_i,
  input  logic [7:0]        tag_i,
  input  apg_pkg::cfg_t     cfg_i,
  output apg_pkg::div_req_t div_req_o,
  input  apg_pkg::div_rsp_t div_rsp_i,
  output logic              push_o,
  output apg_pkg::item_t    item_o,
  input  logic              full_i,
  output logic              busy_o
);

  localparam logic [6:0] MAXN = 7'(MAX_POINTS);

  apg_pkg::front_state_t state_r, state_nxt;

  logic [7:0]         tag_r;
  logic [6:0]         n_r;
  logic signed [32:0] s_r, e_r;
  logic               sneg_r;
  logic signed [49:0] step_r;
  logic signed [57:0] ang_r;
  logic [5:0]         k_r;
  logic [57:0]        red_r;
  logic               angneg_r;
  logic [3:0]         j_r;
  logic [40:0]        r_r;
  logic [1:0]         q_r;
  logic [38:0]        rem_r;
  logic [39:0]        msh_r;
  logic [94:0]        prod_r;
  logic [2:0]         mcnt_r;
  logic               zneg_r;

  logic [6:0]         n_eff;
  logic signed [33:0] diff;
  logic [32:0]        diff_mag;
  logic [57:0]        full_sh;
  logic               last_pt;
  logic [63:0]        zmag;

  assign n_eff    = (cfg_i.bar_count > MAXN) ? MAXN : cfg_i.bar_count;
  assign diff     = 34'(e_r) - 34'(s_r);
  assign diff_mag = diff[33] ? 33'(-diff) : 33'(diff);
  assign full_sh  = 58'(apg_pkg::FULL_ANG) << j_r;
  assign last_pt  = ({1'b0, k_r} == 7'(n_r - 1'b1));
  assign zmag     = {1'b0, prod_r[94:32]};

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= apg_pkg::F_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    div_req_o = '0;
    push_o    = 1'b0;
    unique case (state_r)
      apg_pkg::F_IDLE: begin
        if (go_i) begin
          if (cfg_i.bar_count == '0) begin
            state_nxt = apg_pkg::F_EMPTY;
          end else if (cfg_i.full_circle) begin
            div_req_o.go       = 1'b1;
            div_req_o.dividend = apg_pkg::FULL_DEG;
            div_req_o.divisor  = n_eff;
            state_nxt          = apg_pkg::F_DIV_FC;
          end else begin
            state_nxt = apg_pkg::F_PREP;
          end
        end
      end
      apg_pkg::F_EMPTY: begin
        push_o = !full_i;
        if (!full_i) state_nxt = apg_pkg::F_IDLE;
      end
      apg_pkg::F_DIV_FC: begin
        if (div_rsp_i.done) state_nxt = apg_pkg::F_PREP;
      end
      apg_pkg::F_PREP: begin
        if (n_r == 7'd1) begin
          state_nxt = apg_pkg::F_ANG;
        end else begin
          div_req_o.go       = 1'b1;
          div_req_o.dividend = {diff_mag, 16'b0};
          div_req_o.divisor  = n_r - 1'b1;
          state_nxt          = apg_pkg::F_DIV_STEP;
        end
      end
      apg_pkg::F_DIV_STEP: begin
        if (div_rsp_i.done) state_nxt = apg_pkg::F_ANG;
      end
      apg_pkg::F_ANG:      state_nxt = apg_pkg::F_RED_INIT;
      apg_pkg::F_RED_INIT: state_nxt = apg_pkg::F_RED;
      apg_pkg::F_RED: begin
        if (j_r == '0) state_nxt = apg_pkg::F_RFIX;
      end
      apg_pkg::F_RFIX: state_nxt = apg_pkg::F_QSEL;
      apg_pkg::F_QSEL: state_nxt = apg_pkg::F_QADJ;
      apg_pkg::F_QADJ: state_nxt = apg_pkg::F_MUL;
      apg_pkg::F_MUL: begin
        if (mcnt_r == 3'(apg_pkg::MUL_DIGITS - 1)) state_nxt = apg_pkg::F_PUSH;
      end
      apg_pkg::F_PUSH: begin
        push_o = !full_i;
        if (!full_i) state_nxt = last_pt ? apg_pkg::F_IDLE : apg_pkg::F_RED_INIT;
      end
      default: state_nxt = apg_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      apg_pkg::F_IDLE: begin
        tag_r <= tag_i;
        n_r   <= n_eff;
        s_r   <= 33'(cfg_i.start_angle);
        e_r   <= 33'(cfg_i.end_angle);
      end
      apg_pkg::F_DIV_FC: begin
        if (div_rsp_i.done) begin
          s_r <= '0;
          e_r <= $signed(33'(apg_pkg::FULL_DEG) - 33'(div_rsp_i.quot));
        end
      end
      apg_pkg::F_PREP: begin
        step_r <= '0;
        sneg_r <= diff[33];
      end
      apg_pkg::F_DIV_STEP: begin
        if (div_rsp_i.done) begin
          step_r <= sneg_r ? -$signed({1'b0, div_rsp_i.quot}) : $signed({1'b0, div_rsp_i.quot});
        end
      end
      apg_pkg::F_ANG: begin
        ang_r <= $signed({{9{s_r[32]}}, s_r, 16'b0});
        k_r   <= '0;
      end
      apg_pkg::F_RED_INIT: begin
        red_r    <= ang_r[57] ? 58'(-ang_r) : 58'(ang_r);
        angneg_r <= ang_r[57];
        j_r      <= 4'(apg_pkg::RED_STEPS - 1);
      end
      apg_pkg::F_RED: begin
        if (red_r >= full_sh) red_r <= red_r - full_sh;
        j_r <= j_r - 1'b1;
      end
      apg_pkg::F_RFIX: begin
        // floor modulo for negative angles
        r_r <= (angneg_r && red_r != '0) ? apg_pkg::FULL_ANG - red_r[40:0] : red_r[40:0];
      end
      apg_pkg::F_QSEL: begin
        priority if (r_r >= 41'(3 * apg_pkg::QUARTER_ANG)) begin
          q_r   <= 2'd3;
          rem_r <= 39'(r_r - 41'(3 * apg_pkg::QUARTER_ANG));
        end else if (r_r >= 41'(2 * apg_pkg::QUARTER_ANG)) begin
          q_r   <= 2'd2;
          rem_r <= 39'(r_r - 41'(2 * apg_pkg::QUARTER_ANG));
        end else if (r_r >= apg_pkg::QUARTER_ANG) begin
          q_r   <= 2'd1;
          rem_r <= 39'(r_r - apg_pkg::QUARTER_ANG);
        end else begin
          q_r   <= 2'd0;
          rem_r <= r_r[38:0];
        end
      end
      apg_pkg::F_QADJ: begin
        // residue above half a quadrant moves to the next quadrant, negative
        if ({2'b0, rem_r} > apg_pkg::HALF_Q_ANG) begin
          q_r    <= q_r + 1'b1;
          msh_r  <= 40'(apg_pkg::QUARTER_ANG[38:0] - rem_r);
          zneg_r <= 1'b1;
        end else begin
          msh_r  <= {1'b0, rem_r};
          zneg_r <= 1'b0;
        end
        prod_r <= '0;
        mcnt_r <= '0;
      end
      apg_pkg::F_MUL: begin
        // one byte of the magnitude per cycle, most significant first
        prod_r <= {prod_r[86:0], 8'b0} +
                  95'({55'b0, msh_r[39:32]} * {8'b0, apg_pkg::DEG2RAD_Q60});
        msh_r  <= {msh_r[31:0], 8'b0};
        mcnt_r <= mcnt_r + 1'b1;
      end
      apg_pkg::F_PUSH: begin
        if (!full_i && !last_pt) begin
          ang_r <= ang_r + 58'(step_r);
          k_r   <= k_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    item_o.tag   = tag_r;
    item_o.idx   = k_r;
    item_o.quad  = q_r;
    item_o.z     = zneg_r ? -$signed(zmag) : $signed(zmag);
    item_o.empty = 1'b0;
    item_o.last  = last_pt;
    if (state_r == apg_pkg::F_EMPTY) begin
      item_o.idx   = '0;
      item_o.empty = 1'b1;
      item_o.last  = 1'b1;
    end
  end

  assign busy_o = (state_r != apg_pkg::F_IDLE);

endmodule

// ----- sv/apg_back.sv -----
// apg_back: CORDIC rotation of the radius, quadrant fix-up, rounding,
// centre offset and saturation; drives the result registers; uses apg_pkg
module apg_back #(
  parameter int CORDIC_STEPS = apg_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               not_empty_i,
  output logic               pop_o,
  input  apg_pkg::item_t     item_i,
  input  apg_pkg::cfg_t      cfg_i,
  output logic               busy_o,
  output logic               out_valid_o,
  output logic [7:0]         out_tag_echo_o,
  output logic [5:0]         out_bar_index_o,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic [30:0]        out_area_out_o,
  output logic               out_empty_res_o,
  output logic               out_last_o
);

  localparam int IW = $clog2(CORDIC_STEPS);
  localparam logic [apg_pkg::ATAN_N*64-1:0] ATAN_ALL = apg_pkg::atan_table();

  apg_pkg::back_state_t state_r, state_nxt;

  logic [7:0]         tag_r;
  logic [5:0]         idx_r;
  logic [1:0]         quad_r;
  logic               empty_r, last_r;
  logic signed [49:0] x_r, y_r;
  logic signed [63:0] z_r;
  logic [IW-1:0]      i_r;
  logic signed [33:0] rx_r, ry_r;

  logic               out_valid_r;
  logic [7:0]         out_tag_r;
  logic [5:0]         out_idx_r;
  logic signed [31:0] out_x_r, out_y_r;
  logic [30:0]        out_area_r;
  logic               out_empty_r, out_last_r;

  logic [62:0]        gain_prod;
  logic signed [49:0] xs, ys, xq, yq, xrnd, yrnd;
  logic signed [63:0] atan_i;
  logic signed [35:0] sum_x, sum_y;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  assign gain_prod = 63'({32'b0, cfg_i.arc_radius} * {31'b0, apg_pkg::GAIN_Q32});
  assign xs        = x_r >>> i_r;
  assign ys        = y_r >>> i_r;
  assign atan_i    = $signed(ATAN_ALL[i_r*64 +: 64]);
  assign sum_x     = 36'(cfg_i.center_x) + 36'(rx_r);
  assign sum_y     = 36'(cfg_i.center_y) + 36'(ry_r);

  always_comb begin
    unique case (quad_r)
      2'd1: begin xq = -y_r; yq = x_r; end
      2'd2: begin xq = -x_r; yq = -y_r; end
      2'd3: begin xq = y_r;  yq = -x_r; end
      default: begin xq = x_r; yq = y_r; end
    endcase
    xrnd = xq + 50'sd32768;
    yrnd = yq + 50'sd32768;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apg_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == apg_pkg::B_OUT);
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop_o     = 1'b0;
    unique case (state_r)
      apg_pkg::B_IDLE: begin
        if (not_empty_i) begin
          pop_o     = 1'b1;
          state_nxt = item_i.empty ? apg_pkg::B_OUT : apg_pkg::B_ITER;
        end
      end
      apg_pkg::B_ITER: begin
        if (i_r == IW'(CORDIC_STEPS - 1)) state_nxt = apg_pkg::B_ROT;
      end
      apg_pkg::B_ROT: state_nxt = apg_pkg::B_OUT;
      apg_pkg::B_OUT: state_nxt = apg_pkg::B_IDLE;
      default: state_nxt = apg_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      apg_pkg::B_IDLE: begin
        tag_r   <= item_i.tag;
        idx_r   <= item_i.idx;
        quad_r  <= item_i.quad;
        empty_r <= item_i.empty;
        last_r  <= item_i.last;
        x_r     <= $signed({3'b0, gain_prod[62:16]});
        y_r     <= '0;
        z_r     <= item_i.z;
        i_r     <= '0;
      end
      apg_pkg::B_ITER: begin
        if (!z_r[63]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_i;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_i;
        end
        i_r <= i_r + 1'b1;
      end
      apg_pkg::B_ROT: begin
        rx_r <= xrnd[49:16];
        ry_r <= yrnd[49:16];
      end
      apg_pkg::B_OUT: begin
        out_tag_r   <= tag_r;
        out_empty_r <= empty_r;
        out_last_r  <= last_r;
        if (empty_r) begin
          out_idx_r  <= '0;
          out_x_r    <= '0;
          out_y_r    <= '0;
          out_area_r <= '0;
        end else begin
          out_idx_r  <= idx_r;
          out_x_r    <= sat32(sum_x);
          out_y_r    <= sat32(sum_y);
          out_area_r <= cfg_i.bar_area;
        end
      end
      default: ;
    endcase
  end

  assign busy_o          = (state_r != apg_pkg::B_IDLE);
  assign out_valid_o     = out_valid_r;
  assign out_tag_echo_o  = out_tag_r;
  assign out_bar_index_o = out_idx_r;
  assign out_pos_x_o     = out_x_r;
  assign out_pos_y_o     = out_y_r;
  assign out_area_out_o  = out_area_r;
  assign out_empty_res_o = out_empty_r;
  assign out_last_o      = out_last_r;

endmodule

// ----- sv/arc_point_generator.sv -----
// arc_point_generator: top level with configuration registers, front end,
// divider, job queue and CORDIC back end; depends on apg_pkg and all apg_* modules

// A request is taken when start is high and busy is low; the block then emits
// one result per point (bar_count capped at MAX_POINTS), index 0 first, each
// shown for a single cycle on out_valid with out_last on the final one, and it
// must be taken then: there is no way to hold results back. A zero count gives
// a single result with out_empty_res set. With the default settings the CORDIC
// back end sets the pace, while the front end prepares the next point in the
// background. Before the first point the front end spends up to two divides
// (one for full-circle mode, one for the angle step) plus the angle reduction.
// busy stays high until the last point has left the CORDIC; configuration is
// to be written by the user only while busy is low; the block itself does not
// enforce this.
module arc_point_generator #(
  parameter int MAX_POINTS   = apg_pkg::MAX_POINTS_DEF,
  parameter int CORDIC_STEPS = apg_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         in_request_tag,
  output logic               out_valid,
  output logic [7:0]         out_tag_echo,
  output logic [5:0]         out_bar_index,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [30:0]        out_area_out,
  output logic               out_empty_res,
  output logic               out_last
);

  apg_pkg::cfg_t     cfg_r;
  apg_pkg::div_req_t div_req;
  apg_pkg::div_rsp_t div_rsp;
  apg_pkg::item_t    push_item, pop_item;
  logic              go, push, pop, q_full, q_not_empty, front_busy, back_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (apg_pkg::cfg_idx_t'(cfg_index))
        apg_pkg::REG_BAR_COUNT:   cfg_r.bar_count   <= cfg_wdata[6:0];
        apg_pkg::REG_FULL_CIRCLE: cfg_r.full_circle <= cfg_wdata[0];
        apg_pkg::REG_START_ANGLE: cfg_r.start_angle <= cfg_wdata;
        apg_pkg::REG_END_ANGLE:   cfg_r.end_angle   <= cfg_wdata;
        apg_pkg::REG_CENTER_X:    cfg_r.center_x    <= cfg_wdata;
        apg_pkg::REG_CENTER_Y:    cfg_r.center_y    <= cfg_wdata;
        apg_pkg::REG_ARC_RADIUS:  cfg_r.arc_radius  <= cfg_wdata[30:0];
        apg_pkg::REG_BAR_AREA:    cfg_r.bar_area    <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  assign go   = start && !busy;
  assign busy = front_busy || q_not_empty || back_busy;

  apg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  apg_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .go_i      (go),
    .tag_i     (in_request_tag),
    .cfg_i     (cfg_r),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp),
    .push_o    (push),
    .item_o    (push_item),
    .full_i    (q_full),
    .busy_o    (front_busy)
  );

  apg_fifo #(.DEPTH(apg_pkg::QUEUE_DEPTH)) u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_item),
    .not_empty_o (q_not_empty)
  );

  apg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .not_empty_i     (q_not_empty),
    .pop_o           (pop),
    .item_i          (pop_item),
    .cfg_i           (cfg_r),
    .busy_o          (back_busy),
    .out_valid_o     (out_valid),
    .out_tag_echo_o  (out_tag_echo),
    .out_bar_index_o (out_bar_index),
    .out_pos_x_o     (out_pos_x),
    .out_pos_y_o     (out_pos_y),
    .out_area_out_o  (out_area_out),
    .out_empty_res_o (out_empty_res),
    .out_last_o      (out_last)
  );

`ifndef SYNTHESIS
  a_busy_after_go: assert property (@(posedge clk) disable iff (!rst_n) go |=> busy)
    else $error("accepted transaction did not raise busy");
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_last)
    else $error("empty result not marked last");
  a_last_then_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result straight after the last one of a transaction");
`endif

endmodule

// ----- sim/tb_arc_point_generator.sv -----
// tb_arc_point_generator: self-checking bench for the arc point generator
// depends on apg_pkg and arc_point_generator; predicts every point in the bench
module tb_arc_point_generator;

  typedef struct {
    logic [7:0]  tag;
    logic [5:0]  idx;
    logic [31:0] px;
    logic [31:0] py;
    logic [30:0] area;
    logic        empty;
    logic        last;
  } point_t;

  typedef struct {
    bit                the_cfg_flag_unused;
  } unused_t;

  typedef struct {
    bit                is_cfg;
    apg_pkg::cfg_idx_t reg_sel;
    logic [31:0]       value;
    logic [7:0]        tag;
  } txn_t;

  localparam logic [63:0] D2R = apg_pkg::PI_Q60 / 64'd180;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic start = 0;
  logic [7:0] in_request_tag = '0;
  logic busy, out_valid, out_empty_res, out_last;
  logic [7:0] out_tag_echo;
  logic [5:0] out_bar_index;
  logic signed [31:0] out_pos_x, out_pos_y;
  logic [30:0] out_area_out;

  arc_point_generator dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .start(start), .busy(busy),
    .in_request_tag(in_request_tag), .out_valid(out_valid),
    .out_tag_echo(out_tag_echo), .out_bar_index(out_bar_index),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_area_out(out_area_out),
    .out_empty_res(out_empty_res), .out_last(out_last)
  );

  // model copy of the registers
  logic [6:0]  m_count;
  logic        m_full;
  logic [31:0] m_start, m_end, m_cx, m_cy;
  logic [30:0] m_radius, m_area;

  txn_t   pending[$];
  point_t expected_points[$];
  int     mismatches = 0;
  int     reqs_sent = 0;   // requests sent
  int     reqs_done = 0;   // requests whose last point has been seen

  initial forever #2 clk = ~clk;

  function automatic longint atan_entry(int i);
    longint acc;
    longint e;
    if (i == 0) return longint'(apg_pkg::PI_Q60 >> 2);
    acc = 0;
    for (int k = 0; k < 31; k++) begin
      e = i * (2 * k + 1);
      if (e <= 60) begin
        if (k % 2) acc -= longint'((64'd1 << (60 - e)) / (2 * k + 1));
        else acc += longint'((64'd1 << (60 - e)) / (2 * k + 1));
      end
    end
    return acc;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // offsets in Q16.16 for an angle with 32 fraction bits
  task automatic arc_offset(input longint ang, output longint dx, output longint dy);
    longint full_a, quarter, r, rem, z, x, y, t, xs, ys;
    logic [127:0] prod;
    logic [63:0] m;
    int q;
    bit neg;
    full_a = longint'(360) <<< 32;
    quarter = longint'(90) <<< 32;
    r = ang % full_a;
    if (r < 0) r += full_a;
    q = int'(r / quarter);
    rem = r - longint'(q) * quarter;
    if (rem > quarter / 2) begin
      rem -= quarter;
      q++;
    end
    q &= 3;
    neg = rem < 0;
    m = neg ? -rem : rem;
    prod = m * D2R;
    z = longint'(prod >> 32);
    if (neg) z = -z;
    prod = {97'd0, m_radius} * apg_pkg::GAIN_Q32;
    x = longint'(prod >> 16);
    y = 0;
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_entry(i);
      end else begin
        x += ys; y -= xs; z += atan_entry(i);
      end
    end
    case (q)
      1: begin t = x; x = -y; y = t; end
      2: begin x = -x; y = -y; end
      3: begin t = x; x = y; y = -t; end
      default: ;
    endcase
    dx = (x + 32768) >>> 16;
    dy = (y + 32768) >>> 16;
  endtask

  task automatic predict_arc(input logic [7:0] tag);
    point_t p;
    longint s, e, f, stp, dx, dy;
    int n;
    n = m_count;
    if (n == 0) begin
      p = '{tag, 6'd0, 32'd0, 32'd0, 31'd0, 1'b1, 1'b1};
      expected_points.push_back(p);
      return;
    end
    if (n > 64) n = 64;
    if (m_full) begin
      f = longint'(360) <<< 16;
      s = 0;
      e = f - f / n;
    end else begin
      s = longint'($signed(m_start));
      e = longint'($signed(m_end));
    end
    stp = (n > 1) ? ((e - s) * 65536) / (n - 1) : 0;
    for (int k = 0; k < n; k++) begin
      arc_offset(s * 65536 + stp * k, dx, dy);
      p.tag = tag;
      p.idx = k[5:0];
      p.px = 32'(sat32(longint'($signed(m_cx)) + dx));
      p.py = 32'(sat32(longint'($signed(m_cy)) + dy));
      p.area = m_area;
      p.empty = 0;
      p.last = (k + 1 == n);
      expected_points.push_back(p);
    end
  endtask

  task automatic queue_cfg(input apg_pkg::cfg_idx_t r, input logic [31:0] v);
    txn_t t;
    t.is_cfg = 1; t.reg_sel = r; t.value = v; t.tag = '0;
    pending.push_back(t);
  endtask

  task automatic queue_req(input logic [7:0] tag);
    txn_t t;
    t.is_cfg = 0; t.reg_sel = apg_pkg::REG_BAR_COUNT; t.value = '0; t.tag = tag;
    pending.push_back(t);
  endtask

  task automatic queue_setup(input logic [6:0] n, input bit fc, input logic [31:0] sa,
                             input logic [31:0] ea, input logic [31:0] cx,
                             input logic [31:0] cy, input logic [30:0] rad,
                             input logic [30:0] ar);
    queue_cfg(apg_pkg::REG_BAR_COUNT, n);
    queue_cfg(apg_pkg::REG_FULL_CIRCLE, fc);
    queue_cfg(apg_pkg::REG_START_ANGLE, sa);
    queue_cfg(apg_pkg::REG_END_ANGLE, ea);
    queue_cfg(apg_pkg::REG_CENTER_X, cx);
    queue_cfg(apg_pkg::REG_CENTER_Y, cy);
    queue_cfg(apg_pkg::REG_ARC_RADIUS, rad);
    queue_cfg(apg_pkg::REG_BAR_AREA, ar);
  endtask

  // mostly small counts, a few at the extremes and above the cap
  function automatic logic [6:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 7'd0;
    if (r < 10) return 7'($urandom_range(64, 127));
    if (r < 15) return 7'd64;
    return 7'($urandom_range(1, 6));
  endfunction

  function automatic logic [31:0] pick_angle();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return 32'($signed($urandom_range(0, 1440)) - 720) <<< 16 | $urandom_range(0, 65535);
  endfunction

  initial begin
    // directed: reset values, extremes, full circle, single point, count cap
    queue_req(8'h00);
    queue_req(8'hFF);
    queue_setup(7'd1, 1'b0, 32'h002D0000, 32'h0, 32'h0, 32'h0, 31'h00010000, 31'h7FFFFFFF);
    queue_req(8'hA5);
    queue_setup(7'd8, 1'b1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFF0000, 32'h80000000,
                31'h7FFFFFFF, 31'd0);
    queue_req(8'h5A);
    queue_setup(7'd5, 1'b0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                31'h7FFFFFFF, 31'h12345);
    queue_req(8'h01);
    queue_setup(7'd127, 1'b0, 32'hFFA60000, 32'h005A0000, 32'h00640000, 32'hFF9C0000,
                31'h00320000, 31'h00010000);
    queue_req(8'h80);
    queue_setup(7'd3, 1'b0, 32'h002D0000, 32'h00870000, 32'h0, 32'h0, 31'h00640000, 31'd1);
    queue_req(8'h7F);
    queue_setup(7'd2, 1'b1, 32'h0, 32'h0, 32'hFFFFFFFF, 32'h0, 31'd0, 31'h55555555);
    queue_req(8'h33);
    queue_cfg(apg_pkg::REG_BAR_COUNT, 32'hFFFFFF80);  // masks to zero
    queue_req(8'hCC);
    // random phases with random contents
    for (int ph = 0; ph < 40; ph++) begin
      case ($urandom_range(0, 2))
        0: queue_setup(pick_count(), $urandom_range(0, 1), pick_angle(), pick_angle(),
                       $urandom(), $urandom(), $urandom(), $urandom());
        1: queue_setup(pick_count(), $urandom_range(0, 1), pick_angle(), pick_angle(),
                       32'($signed($urandom_range(0, 2000)) - 1000) <<< 16,
                       32'($signed($urandom_range(0, 2000)) - 1000) <<< 16,
                       31'($urandom_range(0, 500)) << 16, $urandom());
        default: queue_cfg(apg_pkg::cfg_idx_t'($urandom_range(0, 7)), $urandom());
      endcase
      repeat ($urandom_range(3, 5)) queue_req(8'($urandom()));
    end
  end

  // driver: requests and register writes; writes wait until the block is idle
  bit pause_gaps;
  int settle;
  int cycle_no = 0;
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    pause_gaps = (cycle_no % 20000) < 5000;
    if (!rst_n) begin
      start <= 0;
      cfg_we <= 0;
      settle <= 0;
    end else if (start && !busy) begin
      // request taken at this edge
      start <= 0;
      cfg_we <= 0;
    end else if (start) begin
      cfg_we <= 0;
    end else if (pending.size() == 0) begin
      cfg_we <= 0;
    end else if (pending[0].is_cfg) begin
      if (reqs_sent == reqs_done && expected_points.size() == 0 && !busy) begin
        if (settle < 40) begin
          settle <= settle + 1;
          cfg_we <= 0;
        end else begin
          txn_t t;
          t = pending.pop_front();
          cfg_we <= 1;
          cfg_index <= t.reg_sel;
          cfg_wdata <= t.value;
          case (t.reg_sel)
            apg_pkg::REG_BAR_COUNT:   m_count = t.value[6:0];
            apg_pkg::REG_FULL_CIRCLE: m_full = t.value[0];
            apg_pkg::REG_START_ANGLE: m_start = t.value;
            apg_pkg::REG_END_ANGLE:   m_end = t.value;
            apg_pkg::REG_CENTER_X:    m_cx = t.value;
            apg_pkg::REG_CENTER_Y:    m_cy = t.value;
            apg_pkg::REG_ARC_RADIUS:  m_radius = t.value[30:0];
            apg_pkg::REG_BAR_AREA:    m_area = t.value[30:0];
            default: ;
          endcase
        end
      end else begin
        cfg_we <= 0;
        settle <= 0;
      end
    end else begin
      cfg_we <= 0;
      settle <= 0;
      if (pause_gaps || $urandom_range(0, 99) >= 12) begin
        txn_t t;
        t = pending.pop_front();
        in_request_tag <= t.tag;
        start <= 1;
        predict_arc(t.tag);
        reqs_sent <= reqs_sent + 1;
      end
    end
  end

  // monitor: compares every strobed point with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      point_t want;
      if (out_last) reqs_done <= reqs_done + 1;
      if (expected_points.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected point: tag %0h idx %0d", out_tag_echo,
                                      out_bar_index);
      end else begin
        want = expected_points.pop_front();
        if (out_tag_echo !== want.tag || out_bar_index !== want.idx ||
            out_pos_x !== want.px || out_pos_y !== want.py ||
            out_area_out !== want.area || out_empty_res !== want.empty ||
            out_last !== want.last) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp tag %0h idx %0d x %0h y %0h area %0h e %0b l %0b / got tag %0h idx %0d x %0h y %0h area %0h e %0b l %0b",
                     want.tag, want.idx, want.px, want.py, want.area, want.empty, want.last,
                     out_tag_echo, out_bar_index, out_pos_x, out_pos_y, out_area_out,
                     out_empty_res, out_last);
        end
      end
    end
  end

  initial begin
    m_count = 0; m_full = 0; m_start = 0; m_end = 0;
    m_cx = 0; m_cy = 0; m_radius = 0; m_area = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    wait (pending.size() == 0 && !start && reqs_sent == reqs_done &&
          expected_points.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_points.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #8000000;
    $display("status: fail");
    $finish;
  end
endmodule
